/* design/fixed_block_free_list_pool_top_defines.svh */
// Assertion macros for the free-list pool
`ifndef FIXED_BLOCK_FREE_LIST_POOL_TOP_DEFINES_SVH
`define FIXED_BLOCK_FREE_LIST_POOL_TOP_DEFINES_SVH

// same-cycle implication, clocked on clk_i, held off during reset
`define FBP_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, clocked on clk_i, held off during reset
`define FBP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* design/fbp_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package fbp_pkg;

  localparam int unsigned POOL_DEPTH = 1024;
  localparam int unsigned IDX_W      = $clog2(POOL_DEPTH);
  localparam int unsigned CNT_W      = $clog2(POOL_DEPTH + 1);
  localparam int unsigned CFG_W      = 13;
  localparam int unsigned SIZE_W     = CFG_W + 1;
  localparam int unsigned OFS_W      = 22;
  localparam int unsigned PROD_W     = IDX_W + SIZE_W;

  localparam logic [CFG_W-1:0] BLOCK_BYTES_RST = CFG_W'(64);
  localparam logic [CFG_W-1:0] MIN_BLOCK_BYTES = CFG_W'(8);
  localparam int unsigned      ALIGN_BYTES     = 16;

  typedef enum logic {
    OP_ALLOC   = 1'b0,
    OP_RELEASE = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    ST_INIT,
    ST_IDLE,
    ST_POP
  } state_e;

  typedef struct packed {
    logic             valid;
    logic [IDX_W-1:0] index;
  } link_t;

  function automatic logic [SIZE_W-1:0] eff_size(input logic [CFG_W-1:0] bytes);
    logic [SIZE_W-1:0] s;
    logic [SIZE_W-1:0] mask;
    s    = (bytes < MIN_BLOCK_BYTES) ? {1'b0, MIN_BLOCK_BYTES} : {1'b0, bytes};
    mask = SIZE_W'(ALIGN_BYTES - 1);
    eff_size = (s + mask) & ~mask;
  endfunction

endpackage

`default_nettype wire

/* design/fbp_chan_if.sv */
`timescale 1ns / 1ps
`default_nettype none

interface fbp_req_if
  import fbp_pkg::*;
();
  logic             valid;
  logic             ready;
  logic             operation;
  logic [IDX_W-1:0] block_index;

  modport source (output valid, output operation, output block_index, input ready);
  modport sink   (input valid, input operation, input block_index, output ready);
endinterface

interface fbp_rsp_if
  import fbp_pkg::*;
();
  logic             valid;
  logic             ready;
  logic             granted;
  logic [IDX_W-1:0] given_index;
  logic [OFS_W-1:0] byte_offset;
  logic             release_dropped;
  logic [CNT_W-1:0] in_use_count;
  logic [CNT_W-1:0] free_count;

  modport source (
    output valid, output granted, output given_index, output byte_offset,
    output release_dropped, output in_use_count, output free_count, input ready
  );
  modport sink (
    input valid, input granted, input given_index, input byte_offset,
    input release_dropped, input in_use_count, input free_count, output ready
  );
endinterface

`default_nettype wire

/* design/fixed_block_free_list_pool_top.sv */
// Fixed-size block pool with a LIFO free list held in a 1024-entry link memory
// with a registered read. After reset a clearing pass loads the link memory,
// one entry a cycle, and no item is accepted until it ends; writes of
// block_bytes are taken at any time. A release, a refused allocate and a
// dropped release are handled in the idle state alone; a granted allocate also
// passes through the pop state, since the new head comes from a read of the
// link memory at the old head. Each item gives one result, held in an output
// register; the next item is accepted only while that register is empty or in
// the cycle its result is taken.
`timescale 1ns / 1ps
`default_nettype none

module fixed_block_free_list_pool_top
  import fbp_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             cfg_we_i,
  input  wire logic [CFG_W-1:0] cfg_wdata_i,
  fbp_req_if.sink               req_i,
  fbp_rsp_if.source             rsp_o
);

  `include "fixed_block_free_list_pool_top_defines.svh"

  state_e            state_q, state_d;
  logic [IDX_W-1:0]  init_cnt_q;
  logic [CFG_W-1:0]  block_bytes_q;
  link_t             head_q, head_d;
  logic [CNT_W-1:0]  in_use_q, in_use_d;

  link_t             link_mem_q [POOL_DEPTH];
  link_t             rdata_q;
  logic              mem_we;
  logic              mem_re;
  logic [IDX_W-1:0]  mem_waddr;
  link_t             mem_wdata;

  logic              ready;
  logic              accept;
  logic              is_release;
  logic              can_grant;
  logic              do_grant;
  logic              do_push;
  logic              do_drop;
  logic [PROD_W-1:0] product;

  logic              rsp_valid_q;
  logic              granted_q;
  logic [IDX_W-1:0]  given_q;
  logic [OFS_W-1:0]  offset_q;
  logic              dropped_q;
  logic [CNT_W-1:0]  in_use_out_q;
  logic [CNT_W-1:0]  free_out_q;

  assign accept     = req_i.valid && ready;
  assign is_release = (req_i.operation == OP_RELEASE);
  assign can_grant  = head_q.valid && (in_use_q < CNT_W'(POOL_DEPTH));
  assign do_grant   = accept && !is_release && can_grant;
  assign do_drop    = accept && is_release && (in_use_q == '0);
  assign do_push    = accept && is_release && (in_use_q != '0)
                    && ({1'b0, req_i.block_index} < CNT_W'(POOL_DEPTH));
  assign product    = head_q.index * eff_size(block_bytes_q);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_INIT: begin
        if (init_cnt_q == IDX_W'(POOL_DEPTH - 1)) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (do_grant) state_d = ST_POP;
      end
      ST_POP: begin
        state_d = ST_IDLE;
      end
      default: state_d = ST_INIT;
    endcase
  end

  always_comb begin
    ready     = 1'b0;
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    mem_waddr = req_i.block_index;
    mem_wdata = head_q;
    unique case (state_q)
      ST_INIT: begin
        mem_we          = 1'b1;
        mem_waddr       = init_cnt_q;
        mem_wdata.valid = (init_cnt_q != '0);
        mem_wdata.index = (init_cnt_q != '0) ? init_cnt_q - IDX_W'(1) : '0;
      end
      ST_IDLE: begin
        ready  = !rsp_valid_q || rsp_o.ready;
        mem_we = do_push;
        mem_re = do_grant;
      end
      ST_POP: begin
        ready = 1'b0;
      end
      default: ready = 1'b0;
    endcase
  end

  assign req_i.ready = ready;

  always_comb begin
    head_d   = head_q;
    in_use_d = in_use_q;
    if (state_q == ST_POP) begin
      head_d = rdata_q;
    end
    if (do_grant) begin
      in_use_d = in_use_q + CNT_W'(1);
    end else if (do_push) begin
      head_d.valid = 1'b1;
      head_d.index = req_i.block_index;
      in_use_d     = in_use_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_INIT;
      init_cnt_q    <= '0;
      block_bytes_q <= BLOCK_BYTES_RST;
      head_q.valid  <= 1'b1;
      head_q.index  <= IDX_W'(POOL_DEPTH - 1);
      in_use_q      <= '0;
      rsp_valid_q   <= 1'b0;
    end else begin
      state_q  <= state_d;
      head_q   <= head_d;
      in_use_q <= in_use_d;
      if (state_q == ST_INIT) init_cnt_q <= init_cnt_q + IDX_W'(1);
      if (cfg_we_i) block_bytes_q <= cfg_wdata_i;
      if (accept) begin
        rsp_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        rsp_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) link_mem_q[mem_waddr] <= mem_wdata;
    if (mem_re) rdata_q <= link_mem_q[head_q.index];
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      granted_q    <= do_grant;
      given_q      <= do_grant ? head_q.index : '0;
      offset_q     <= do_grant ? product[OFS_W-1:0] : '0;
      dropped_q    <= do_drop;
      in_use_out_q <= in_use_d;
      free_out_q   <= CNT_W'(POOL_DEPTH) - in_use_d;
    end
  end

  assign rsp_o.valid           = rsp_valid_q;
  assign rsp_o.granted         = granted_q;
  assign rsp_o.given_index     = given_q;
  assign rsp_o.byte_offset     = offset_q;
  assign rsp_o.release_dropped = dropped_q;
  assign rsp_o.in_use_count    = in_use_out_q;
  assign rsp_o.free_count      = free_out_q;

  `FBP_ASSERT_NOW(a_no_accept_in_init, state_q == ST_INIT, !req_i.ready,
    "item accepted during clearing pass")
  `FBP_ASSERT_NEXT(a_pop_one_cycle, state_q == ST_POP, state_q == ST_IDLE,
    "pop did not return to idle")
  `FBP_ASSERT_NOW(a_counts_sum, rsp_o.valid,
    (rsp_o.in_use_count + rsp_o.free_count) == CNT_W'(POOL_DEPTH),
    "in-use and free counts do not sum to pool size")
  `FBP_ASSERT_NEXT(a_grant_counts, do_grant,
    in_use_q == $past(in_use_q) + CNT_W'(1) && rsp_o.granted && !rsp_o.release_dropped,
    "granted allocate did not advance in-use count")

endmodule

`default_nettype wire
